// ----- rtl/core/vpa_pkg.sv -----
package vpa_pkg;

	// Widths fixed by the field definitions.
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned POS_W  = 8;

	// Pool size after reset.
	localparam logic [ADDR_W-1:0] POOL_RESET = 16'd700;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_NOBLK = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Request opcodes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Fit policies.
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;

	// Cell commands.
	localparam logic [2:0] CM_HOLD   = 3'd0;
	localparam logic [2:0] CM_INIT   = 3'd1;
	localparam logic [2:0] CM_WRITE  = 3'd2;
	localparam logic [2:0] CM_INSERT = 3'd3;
	localparam logic [2:0] CM_ERASE  = 3'd4;

	// Register indexes.
	localparam logic REG_FIT  = 1'b0;
	localparam logic REG_POOL = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic              free;
	} entry_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [POS_W-1:0] pos;
		entry_t           ent_a;
		entry_t           ent_b;
	} cell_ctl_t;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] alloc_size;
		logic [ADDR_W-1:0] release_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted_address;
		logic [ADDR_W-1:0] free_total;
	} res_t;

endpackage

// ----- rtl/core/vpa_cell.sv -----
module vpa_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vpa_pkg::cell_ctl_t ctl,
	input  vpa_pkg::entry_t    lower,
	input  vpa_pkg::entry_t    upper,
	output vpa_pkg::entry_t    ent
);

	localparam logic [vpa_pkg::POS_W:0] MY_IDX = (vpa_pkg::POS_W+1)'(IDX);

	vpa_pkg::entry_t         ent_q;
	vpa_pkg::entry_t         ent_d;
	logic [vpa_pkg::POS_W:0] pos_w;
	logic [vpa_pkg::POS_W:0] pos_p1;

	assign pos_w  = {1'b0, ctl.pos};
	assign pos_p1 = pos_w + 1'b1;

	// Next value of this descriptor from the broadcast command and the neighbours.
	always_comb begin
		ent_d = ent_q;
		unique case (ctl.mode)
			vpa_pkg::CM_INIT: begin
				ent_d = (MY_IDX == '0) ? ctl.ent_a : '0;
			end
			vpa_pkg::CM_WRITE: begin
				if (MY_IDX == pos_w) ent_d = ctl.ent_a;
			end
			vpa_pkg::CM_INSERT: begin
				if (MY_IDX == pos_w) ent_d = ctl.ent_a;
				else if (MY_IDX == pos_p1) ent_d = ctl.ent_b;
				else if (MY_IDX > pos_p1) ent_d = lower;
			end
			vpa_pkg::CM_ERASE: begin
				if (MY_IDX >= pos_w) ent_d = upper;
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if (IDX == 0) ent_q <= '{start: '0, size: vpa_pkg::POOL_RESET, free: 1'b1};
			else ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

	assign ent = ent_q;

endmodule

// ----- rtl/core/variable_partition_allocator.sv -----
// Channel   Ports                          Handshake
// request   start, busy, request           beat taken when start high and busy low
// result    done, result                   one-cycle strobe, cannot be held off
// config    psel, penable, pwrite, paddr,  APB write on access cycle, pready always high
//           pwdata, prdata, pready
// An allocate scans the descriptor chain one entry a cycle, then splits or marks the
// picked block in S_ACT; a free scans likewise, then writes the merged block in
// S_NEXT and erases each merged neighbour in S_ER. A zero-size allocate skips the
// scan and goes straight to the result beat; after each result beat the block
// returns to idle before the next request can be taken.
// Reset leaves one free block of 700 units; busy is low straight after reset, and the
// receiver never stalls a result.
module variable_partition_allocator #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  vpa_pkg::req_t       request,
	output logic                done,
	output vpa_pkg::res_t       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_NEXT = 3'd2;
	localparam logic [2:0] S_ACT  = 3'd3;
	localparam logic [2:0] S_ER   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]        state_q;
	logic              op_q;
	logic [15:0]       size_q;
	logic [15:0]       addr_q;
	logic [IW-1:0]     i_q;
	logic [CW-1:0]     k_q;
	logic              found_q;
	logic [IW-1:0]     pick_q;
	vpa_pkg::entry_t   pick_e_q;
	vpa_pkg::entry_t   prev_q;
	logic [IW-1:0]     erase_pos_q;
	logic [1:0]        nerase_q;
	logic [1:0]        status_q;
	logic [15:0]       grant_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     rov_q;
	logic [15:0]       free_total_q;
	logic [1:0]        fit_q;
	logic [15:0]       pool_q;

	vpa_pkg::entry_t   ents [MAX_BLOCKS];
	vpa_pkg::cell_ctl_t ctl;
	logic [IW-1:0]     rd_idx;
	vpa_pkg::entry_t   rd_e;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	// Chain of descriptor cells.
	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		vpa_pkg::entry_t lo;
		vpa_pkg::entry_t hi;
		if (g == 0) begin : g_lo0
			assign lo = '0;
		end else begin : g_lo
			assign lo = ents[g-1];
		end
		if (g == MAX_BLOCKS - 1) begin : g_hitop
			assign hi = '0;
		end else begin : g_hi
			assign hi = ents[g+1];
		end
		vpa_cell #(.IDX(g)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.lower (lo),
			.upper (hi),
			.ent   (ents[g])
		);
	end

	// Scan read port.
	logic [CW-1:0] pick_p1;
	assign pick_p1 = CW'(pick_q) + 1'b1;
	assign rd_idx  = (state_q == S_NEXT) ? pick_p1[IW-1:0] : i_q;
	assign rd_e    = ents[rd_idx];

	// Scan decisions.
	logic          last;
	logic [IW-1:0] i_nxt;
	logic          a_hit;
	logic          f_hit;
	logic          b_take;
	assign last   = (k_q == count_q - 1'b1);
	assign i_nxt  = ((CW'(i_q) + 1'b1) == count_q) ? '0 : i_q + 1'b1;
	assign a_hit  = rd_e.free && (rd_e.size >= size_q);
	assign f_hit  = (rd_e.start == addr_q) && !rd_e.free;
	assign b_take = a_hit && (!found_q || (rd_e.size < pick_e_q.size));

	// Merge values for a free.
	logic        pf;
	logic        nf;
	logic [15:0] mrg_size;
	assign pf       = (pick_q != '0) && prev_q.free;
	assign nf       = (pick_p1 < count_q) && rd_e.free;
	assign mrg_size = (pf ? prev_q.size : 16'd0) + pick_e_q.size + (nf ? rd_e.size : 16'd0);

	// Split values for an allocate.
	logic          split;
	logic [CW-1:0] cnt_ins;
	logic [CW-1:0] rov_a;
	logic [CW-1:0] rov_b;
	assign split   = pick_e_q.size > size_q;
	assign cnt_ins = split ? count_q + 1'b1 : count_q;
	always_comb begin
		rov_a = CW'(rov_q);
		if (split && (rov_q >= pick_q)) rov_a = CW'(rov_q) + 1'b1;
		if (fit_q == vpa_pkg::FIT_NEXT) rov_a = pick_p1;
		rov_b = (rov_a >= cnt_ins) ? '0 : rov_a;
	end

	// Roving pointer after an erase.
	logic [IW-1:0] rov_e;
	always_comb begin
		rov_e = rov_q;
		if ((rov_q >= erase_pos_q) && (rov_q != '0)) rov_e = rov_q - 1'b1;
		if (CW'(rov_e) >= count_q - 1'b1) rov_e = '0;
	end

	// Command broadcast to the cells.
	always_comb begin
		ctl = '{mode: vpa_pkg::CM_HOLD, pos: '0, ent_a: '0, ent_b: '0};
		if (cfg_wr && (paddr[2] == vpa_pkg::REG_POOL)) begin
			ctl.mode  = vpa_pkg::CM_INIT;
			ctl.ent_a = '{start: '0, size: pwdata[15:0], free: 1'b1};
		end else if (state_q == S_NEXT) begin
			ctl.mode  = vpa_pkg::CM_WRITE;
			ctl.pos   = pf ? vpa_pkg::POS_W'(pick_q - 1'b1) : vpa_pkg::POS_W'(pick_q);
			ctl.ent_a = '{start: (pf ? prev_q.start : pick_e_q.start), size: mrg_size,
				free: 1'b1};
		end else if ((state_q == S_ACT) && !(split && (count_q >= MAX_CNT))) begin
			ctl.mode  = split ? vpa_pkg::CM_INSERT : vpa_pkg::CM_WRITE;
			ctl.pos   = vpa_pkg::POS_W'(pick_q);
			ctl.ent_a = '{start: pick_e_q.start, size: size_q, free: 1'b0};
			ctl.ent_b = '{start: pick_e_q.start + size_q, size: pick_e_q.size - size_q,
				free: 1'b1};
		end else if (state_q == S_ER) begin
			ctl.mode = vpa_pkg::CM_ERASE;
			ctl.pos  = vpa_pkg::POS_W'(erase_pos_q);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= CW'(1);
			rov_q        <= '0;
			free_total_q <= vpa_pkg::POOL_RESET;
			fit_q        <= vpa_pkg::FIT_FIRST;
			pool_q       <= vpa_pkg::POOL_RESET;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == vpa_pkg::REG_FIT) begin
					fit_q <= pwdata[1:0];
				end else begin
					pool_q       <= pwdata[15:0];
					count_q      <= CW'(1);
					rov_q        <= '0;
					free_total_q <= pwdata[15:0];
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= request.opcode;
						size_q  <= request.alloc_size;
						addr_q  <= request.release_address;
						k_q     <= '0;
						found_q <= 1'b0;
						grant_q <= '0;
						if ((request.opcode == vpa_pkg::OP_ALLOC) &&
							(fit_q == vpa_pkg::FIT_NEXT) && (CW'(rov_q) < count_q))
							i_q <= rov_q;
						else
							i_q <= '0;
						if ((request.opcode == vpa_pkg::OP_ALLOC) &&
							(request.alloc_size == '0)) begin
							status_q <= vpa_pkg::ST_NOFIT;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					k_q <= k_q + 1'b1;
					i_q <= i_nxt;
					if (op_q == vpa_pkg::OP_FREE) begin
						if (f_hit) begin
							pick_q   <= i_q;
							pick_e_q <= rd_e;
							state_q  <= S_NEXT;
						end else begin
							prev_q <= rd_e;
							if (last) begin
								status_q <= vpa_pkg::ST_NOBLK;
								state_q  <= S_DONE;
							end
						end
					end else if (fit_q == vpa_pkg::FIT_BEST) begin
						if (b_take) begin
							pick_q   <= i_q;
							pick_e_q <= rd_e;
							found_q  <= 1'b1;
						end
						if (last) begin
							if (b_take || found_q) begin
								state_q <= S_ACT;
							end else begin
								status_q <= vpa_pkg::ST_NOFIT;
								state_q  <= S_DONE;
							end
						end
					end else begin
						if (a_hit) begin
							pick_q   <= i_q;
							pick_e_q <= rd_e;
							state_q  <= S_ACT;
						end else if (last) begin
							status_q <= vpa_pkg::ST_NOFIT;
							state_q  <= S_DONE;
						end
					end
				end
				S_NEXT: begin
					status_q     <= vpa_pkg::ST_OK;
					free_total_q <= free_total_q + pick_e_q.size;
					erase_pos_q  <= pf ? pick_q : pick_p1[IW-1:0];
					nerase_q     <= {1'b0, pf} + {1'b0, nf};
					state_q      <= (pf || nf) ? S_ER : S_DONE;
				end
				S_ACT: begin
					if (split && (count_q >= MAX_CNT)) begin
						status_q <= vpa_pkg::ST_FULL;
					end else begin
						status_q     <= vpa_pkg::ST_OK;
						grant_q      <= pick_e_q.start;
						count_q      <= cnt_ins;
						rov_q        <= rov_b[IW-1:0];
						free_total_q <= free_total_q - size_q;
					end
					state_q <= S_DONE;
				end
				S_ER: begin
					count_q  <= count_q - 1'b1;
					rov_q    <= rov_e;
					nerase_q <= nerase_q - 1'b1;
					if (nerase_q == 2'd1) state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);
	assign result = '{status: status_q, granted_address: grant_q, free_total: free_total_q};

	// Register read-back.
	always_comb begin
		unique case (paddr[2])
			vpa_pkg::REG_FIT:  prdata = {30'd0, fit_q};
			vpa_pkg::REG_POOL: prdata = {16'd0, pool_q};
			default:           prdata = '0;
		endcase
	end

	// The table always holds between one and MAX_BLOCKS descriptors.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= MAX_CNT))
		else $error("descriptor count out of range");

	// The roving pointer always names a live descriptor.
	a_rov_live: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(rov_q) < count_q)
		else $error("roving pointer beyond table");

	// An accepted request makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// A result strobe lasts one cycle and frees the block.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not a single beat");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int NBLK        = 32;
	localparam int SETTLE      = NBLK + 12;
	localparam int CYCLE_LIMIT = 2000000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	vpa_pkg::req_t  request;
	logic           done;
	vpa_pkg::res_t  result;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	variable_partition_allocator #(.MAX_BLOCKS(NBLK)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Allocator image kept by the testbench.
	logic [15:0] blk_start [NBLK];
	logic [15:0] blk_size  [NBLK];
	bit          blk_free  [NBLK];
	int          blk_count;
	int          rove;
	logic [1:0]  policy;
	logic [15:0] pool;

	vpa_pkg::res_t expected_results [$];
	logic [15:0]   live_addrs [$];
	int            errors;
	int            cycles;
	int            n_sent;
	int            n_checked;
	int            n_full;

	// Clock of period 10 ns.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void table_reset();
		for (int i = 0; i < NBLK; i++) begin
			blk_start[i] = '0;
			blk_size[i]  = '0;
			blk_free[i]  = 1'b0;
		end
		blk_size[0] = pool;
		blk_free[0] = 1'b1;
		blk_count   = 1;
		rove        = 0;
	endfunction

	function automatic logic [15:0] free_space();
		logic [15:0] s;
		s = '0;
		for (int i = 0; i < blk_count; i++)
			if (blk_free[i])
				s = s + blk_size[i];
		return s;
	endfunction

	function automatic void table_erase(int e);
		for (int j = e; j + 1 < blk_count; j++) begin
			blk_start[j] = blk_start[j+1];
			blk_size[j]  = blk_size[j+1];
			blk_free[j]  = blk_free[j+1];
		end
		blk_count--;
		if (rove >= e && rove > 0)
			rove--;
		if (rove >= blk_count)
			rove = 0;
	endfunction

	function automatic logic [1:0] table_alloc(logic [15:0] size, output logic [15:0] grant);
		int  pick;
		int  idx;
		int  first;
		bit  found;
		logic [15:0] best;
		pick  = 0;
		found = 1'b0;
		best  = '0;
		grant = '0;
		if (size == 0)
			return vpa_pkg::ST_NOFIT;
		if (policy == vpa_pkg::FIT_NEXT) begin
			first = (rove < blk_count) ? rove : 0;
			for (int k = 0; k < blk_count && !found; k++) begin
				idx = first + k;
				if (idx >= blk_count)
					idx -= blk_count;
				if (blk_free[idx] && blk_size[idx] >= size) begin
					pick  = idx;
					found = 1'b1;
				end
			end
		end else if (policy == vpa_pkg::FIT_BEST) begin
			for (int i = 0; i < blk_count; i++)
				if (blk_free[i] && blk_size[i] >= size && (!found || blk_size[i] < best)) begin
					pick  = i;
					best  = blk_size[i];
					found = 1'b1;
				end
		end else begin
			for (int i = 0; i < blk_count && !found; i++)
				if (blk_free[i] && blk_size[i] >= size) begin
					pick  = i;
					found = 1'b1;
				end
		end
		if (!found)
			return vpa_pkg::ST_NOFIT;
		if (blk_size[pick] > size) begin
			if (blk_count >= NBLK)
				return vpa_pkg::ST_FULL;
			for (int k = blk_count; k > pick; k--) begin
				blk_start[k] = blk_start[k-1];
				blk_size[k]  = blk_size[k-1];
				blk_free[k]  = blk_free[k-1];
			end
			blk_count++;
			blk_start[pick+1] = blk_start[pick] + size;
			blk_size[pick+1]  = blk_size[pick] - size;
			blk_free[pick+1]  = 1'b1;
			blk_size[pick]    = size;
			if (rove >= pick)
				rove++;
		end
		blk_free[pick] = 1'b0;
		grant = blk_start[pick];
		if (policy == vpa_pkg::FIT_NEXT)
			rove = pick + 1;
		if (rove >= blk_count)
			rove = 0;
		return vpa_pkg::ST_OK;
	endfunction

	function automatic logic [1:0] table_release(logic [15:0] addr);
		int i;
		int cur;
		for (i = 0; i < blk_count; i++)
			if (blk_start[i] == addr && !blk_free[i])
				break;
		if (i >= blk_count)
			return vpa_pkg::ST_NOBLK;
		blk_free[i] = 1'b1;
		cur = i;
		if (cur > 0 && blk_free[cur-1]) begin
			blk_size[cur-1] = blk_size[cur-1] + blk_size[cur];
			table_erase(cur);
			cur--;
		end
		if (cur + 1 < blk_count && blk_free[cur+1]) begin
			blk_size[cur] = blk_size[cur] + blk_size[cur+1];
			table_erase(cur + 1);
		end
		return vpa_pkg::ST_OK;
	endfunction

	// Works out the result of one request and updates the image.
	function automatic vpa_pkg::res_t predict_request(vpa_pkg::req_t rq);
		vpa_pkg::res_t r;
		logic [15:0]   g;
		g = '0;
		if (rq.opcode == vpa_pkg::OP_ALLOC) begin
			r.status = table_alloc(rq.alloc_size, g);
			if (r.status != vpa_pkg::ST_OK)
				g = '0;
		end else begin
			r.status = table_release(rq.release_address);
		end
		r.granted_address = g;
		r.free_total      = free_space();
		return r;
	endfunction

	// Result checker: every done beat against the oldest expectation.
	always @(posedge clk) begin
		vpa_pkg::res_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (result.status != want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result.status);
					errors++;
				end
				if (result.granted_address != want.granted_address) begin
					$error("granted_address: expected %0d, actual %0d",
						want.granted_address, result.granted_address);
					errors++;
				end
				if (result.free_total != want.free_total) begin
					$error("free_total: expected %0d, actual %0d",
						want.free_total, result.free_total);
					errors++;
				end
			end
		end
	end

	// Sends one request beat, then idles for a random gap that may be zero.
	task automatic send_request(logic op, logic [15:0] size, logic [15:0] addr);
		vpa_pkg::req_t rq;
		vpa_pkg::res_t r;
		int            gap;
		rq.opcode          = op;
		rq.alloc_size      = size;
		rq.release_address = addr;
		start   <= 1'b1;
		request <= rq;
		do
			@(posedge clk);
		while (busy);
		r = predict_request(rq);
		expected_results.insert(expected_results.size(), r);
		n_sent++;
		if (r.status == vpa_pkg::ST_FULL)
			n_full++;
		if (op == vpa_pkg::OP_ALLOC && r.status == vpa_pkg::ST_OK)
			live_addrs.insert(live_addrs.size(), r.granted_address);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic alloc_units(logic [15:0] size);
		send_request(vpa_pkg::OP_ALLOC, size, 16'($urandom));
	endtask

	task automatic release_block(logic [15:0] addr);
		send_request(vpa_pkg::OP_FREE, 16'($urandom), addr);
	endtask

	// Lowers start and waits until every result has come back.
	task automatic drain();
		@(posedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB register write: setup cycle then access cycle.
	task automatic reg_write(logic regsel, logic [31:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regsel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (regsel == vpa_pkg::REG_FIT) begin
			policy = value[1:0];
		end else begin
			pool = value[15:0];
			table_reset();
			live_addrs.delete();
		end
		@(posedge clk);
	endtask

	// Sizes, exact fit, merging and free misses under first fit.
	task automatic test_basic_requests();
		alloc_units(16'd0);
		alloc_units(16'hFFFF);
		alloc_units(16'd100);
		alloc_units(16'd200);
		alloc_units(16'd50);
		release_block(16'd100);
		release_block(16'd100);
		release_block(16'hFFFF);
		release_block(16'd0);
		alloc_units(16'd300);
		release_block(16'd300);
		release_block(16'd350);
		alloc_units(16'd700);
		release_block(16'd0);
	endtask

	// Splits until the table is full, then a refused split, an exact fit and a request that finds no fit.
	task automatic test_table_full();
		reg_write(vpa_pkg::REG_FIT, {30'd0, vpa_pkg::FIT_FIRST});
		reg_write(vpa_pkg::REG_POOL, 32'd64);
		for (int i = 0; i < NBLK - 1; i++)
			alloc_units(16'd1);
		alloc_units(16'd1);
		alloc_units(16'd33);
		alloc_units(16'd1);
		release_block(16'd5);
		alloc_units(16'd1);
	endtask

	// Zero pool, the largest pool and the unused policy code.
	task automatic test_pool_extremes();
		reg_write(vpa_pkg::REG_POOL, 32'd0);
		alloc_units(16'd1);
		alloc_units(16'd0);
		release_block(16'd0);
		reg_write(vpa_pkg::REG_POOL, 32'd65535);
		reg_write(vpa_pkg::REG_FIT, 32'd3);
		alloc_units(16'hFFFF);
		release_block(16'd0);
		alloc_units(16'h8000);
		alloc_units(16'h7FFF);
		alloc_units(16'd1);
	endtask

	// Random traffic: mostly frees of live blocks and fitting sizes, some noise.
	task automatic test_random_traffic(int items, logic [1:0] pol, logic [15:0] psize);
		int          pick;
		int          roll;
		logic [15:0] addr;
		reg_write(vpa_pkg::REG_FIT, {30'd0, pol});
		reg_write(vpa_pkg::REG_POOL, {16'd0, psize});
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 42 && live_addrs.size() != 0) begin
				pick = $urandom_range(0, live_addrs.size() - 1);
				addr = live_addrs[pick];
				live_addrs.delete(pick);
				release_block(addr);
			end else if (roll < 48) begin
				release_block(16'($urandom));
			end else if (roll < 53) begin
				alloc_units(16'($urandom));
			end else if (roll < 56) begin
				alloc_units(16'd0);
			end else begin
				alloc_units(16'($urandom_range(1, (psize > 16) ? psize / 8 : 2)));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		errors    = 0;
		cycles    = 0;
		n_sent    = 0;
		n_checked = 0;
		n_full    = 0;
		policy    = vpa_pkg::FIT_FIRST;
		pool      = vpa_pkg::POOL_RESET;
		table_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_requests();
		test_table_full();
		test_pool_extremes();
		test_random_traffic(200, vpa_pkg::FIT_FIRST, 16'd700);
		test_random_traffic(200, vpa_pkg::FIT_NEXT, 16'd700);
		test_random_traffic(200, vpa_pkg::FIT_BEST, 16'd700);
		test_random_traffic(150, vpa_pkg::FIT_NEXT, 16'd64);
		test_random_traffic(150, vpa_pkg::FIT_BEST, 16'd40);
		test_random_traffic(150, vpa_pkg::FIT_FIRST, 16'd96);
		test_random_traffic(150, 2'd3, 16'd1000);
		test_random_traffic(200, vpa_pkg::FIT_NEXT, 16'd65535);
		test_random_traffic(150, vpa_pkg::FIT_BEST, 16'd65535);
		test_random_traffic(150, vpa_pkg::FIT_FIRST, 16'hA5A5);
		test_random_traffic(100, vpa_pkg::FIT_NEXT, 16'd1);
		drain();

		$display("Sent %0d requests over all fit policies and pool sizes 0 to 65535;",
			n_sent);
		$display("%0d results checked, %0d of them table-full rejections.", n_checked, n_full);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
